// ===== sv/dmdc_pkg.sv =====
package dmdc_pkg;

  // Default geometry of the sample path
  localparam int SAMPLE_BITS_DEF   = 10;
  localparam int FRACTION_BITS_DEF = 16;

  // Fixed field widths
  localparam int WEIGHT_BITS = 16;
  localparam int THRESH_BITS = 10;

  // Register port geometry
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WEIGHT_A  = 2'd1,
    REG_WEIGHT_B  = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  localparam logic [THRESH_BITS-1:0] THRESHOLD_RST = 10'd35;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RST    = 16'd328;

  typedef enum logic [1:0] {
    TRK_LOW  = 2'd0,
    TRK_RISE = 2'd1,
    TRK_HIGH = 2'd2,
    TRK_FALL = 2'd3
  } trk_t;

  localparam logic signed [1:0] PULSE_NONE = 2'sd0;
  localparam logic signed [1:0] PULSE_FWD  = 2'sd1;
  localparam logic signed [1:0] PULSE_REV  = -2'sd1;

  // Pipeline control shared by the lanes and the sequencer
  typedef struct packed {
    logic take;   // request accepted into the average stage
    logic prime;  // accepted request only loads the averages
    logic adv;    // stage-1 request moves to the result register
    logic load;   // the moving request was a loading one
  } ctrl_t;

endpackage

// ===== sv/dmdc_lane.sv =====
module dmdc_lane #(
  parameter int SAMPLE_BITS   = dmdc_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = dmdc_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dmdc_pkg::ctrl_t                    ctrl,
  input  logic [SAMPLE_BITS-1:0]             sample,
  input  logic [dmdc_pkg::WEIGHT_BITS-1:0]   weight,
  input  logic [dmdc_pkg::THRESH_BITS-1:0]   threshold,
  output dmdc_pkg::trk_t                     track,
  output dmdc_pkg::trk_t                     track_next
);

  localparam int AW   = SAMPLE_BITS + FRACTION_BITS;
  localparam int PW   = AW + dmdc_pkg::WEIGHT_BITS + 2;
  localparam int SUMW = ((SAMPLE_BITS > dmdc_pkg::THRESH_BITS) ? SAMPLE_BITS
                        : dmdc_pkg::THRESH_BITS) + 1;

  logic [AW-1:0]          avg;
  logic [AW-1:0]          avg_next;
  logic [SAMPLE_BITS-1:0] x_hold;
  logic signed [AW:0]     diff;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   step;
  logic [SUMW-1:0]        level;
  logic                   mark;

  // Average stage: floored weighted step toward the new sample, or a direct load on priming
  always_comb begin
    diff = $signed({1'b0, sample, {FRACTION_BITS{1'b0}}}) - $signed({1'b0, avg});
    prod = PW'(diff) * PW'($signed({1'b0, weight}));
    step = prod >>> dmdc_pkg::WEIGHT_BITS;
    if (ctrl.prime) begin
      avg_next = {sample, {FRACTION_BITS{1'b0}}};
    end else begin
      avg_next = avg + step[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      avg    <= avg_next;
      x_hold <= sample;
    end
  end

  // Mark test: integer part of the average at or above the held sample plus the threshold
  always_comb begin
    level = SUMW'(x_hold) + SUMW'(threshold);
    mark  = SUMW'(avg[AW-1:FRACTION_BITS]) >= level;
    case (track)
      dmdc_pkg::TRK_LOW:  track_next = mark ? dmdc_pkg::TRK_RISE : dmdc_pkg::TRK_LOW;
      dmdc_pkg::TRK_RISE: track_next = mark ? dmdc_pkg::TRK_HIGH : dmdc_pkg::TRK_LOW;
      dmdc_pkg::TRK_HIGH: track_next = mark ? dmdc_pkg::TRK_HIGH : dmdc_pkg::TRK_FALL;
      dmdc_pkg::TRK_FALL: track_next = mark ? dmdc_pkg::TRK_FALL : dmdc_pkg::TRK_LOW;
      default:            track_next = dmdc_pkg::TRK_LOW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track <= dmdc_pkg::TRK_LOW;
    end else if (ctrl.adv && !ctrl.load) begin
      track <= track_next;
    end
  end

endmodule

// ===== sv/dmdc_seq.sv =====
module dmdc_seq (
  input  logic                clk,
  input  logic                rst,
  input  dmdc_pkg::ctrl_t     ctrl,
  input  dmdc_pkg::trk_t      trk_a,
  input  dmdc_pkg::trk_t      trk_b,
  output logic signed [1:0]   pulse
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'd0,
    S_AFIRST = 4'd1,
    S_ABOTH  = 4'd2,
    S_MARK   = 4'd3,
    S_BFIRST = 4'd4,
    S_BBOTH  = 4'd5,
    S_AFALL  = 4'd6,
    S_BFALL  = 4'd7,
    S_BLAST  = 4'd8,
    S_ALAST  = 4'd9
  } seq_t;

  seq_t              state;
  seq_t              state_next;
  logic              armed_fwd;
  logic              armed_rev;
  logic              armed_fwd_next;
  logic              armed_rev_next;
  logic signed [1:0] pulse_next;
  logic              step;

  assign step = ctrl.adv && !ctrl.load;

  always_comb begin
    state_next     = state;
    armed_fwd_next = armed_fwd;
    armed_rev_next = armed_rev;
    pulse_next     = dmdc_pkg::PULSE_NONE;
    case (state)
      S_IDLE: begin
        armed_fwd_next = 1'b1;
        armed_rev_next = 1'b1;
        if (trk_a == dmdc_pkg::TRK_RISE) state_next = S_AFIRST;
        if (trk_b == dmdc_pkg::TRK_RISE) state_next = S_BFIRST;
      end
      S_AFIRST: begin
        if (trk_b == dmdc_pkg::TRK_RISE) state_next = S_ABOTH;
      end
      S_ABOTH: begin
        if (armed_fwd) pulse_next = dmdc_pkg::PULSE_FWD;
        state_next = S_MARK;
      end
      S_MARK: begin
        if (trk_b == dmdc_pkg::TRK_FALL) state_next = S_BFALL;
        if (trk_a == dmdc_pkg::TRK_FALL) state_next = S_AFALL;
      end
      S_BFALL: begin
        if (trk_b == dmdc_pkg::TRK_HIGH || trk_b == dmdc_pkg::TRK_RISE) state_next = S_MARK;
        if (trk_a == dmdc_pkg::TRK_FALL) state_next = S_ALAST;
      end
      S_ALAST: begin
        if (armed_rev) pulse_next = dmdc_pkg::PULSE_REV;
        state_next = S_IDLE;
      end
      S_BFIRST: begin
        if (trk_a == dmdc_pkg::TRK_RISE) state_next = S_BBOTH;
      end
      S_BBOTH: begin
        if (armed_rev) pulse_next = dmdc_pkg::PULSE_REV;
        state_next = S_MARK;
      end
      S_AFALL: begin
        if (trk_a == dmdc_pkg::TRK_HIGH || trk_a == dmdc_pkg::TRK_RISE) state_next = S_MARK;
        if (trk_b == dmdc_pkg::TRK_FALL) state_next = S_BLAST;
      end
      S_BLAST: begin
        if (armed_fwd) pulse_next = dmdc_pkg::PULSE_FWD;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // Drop the arm flag of the sign just emitted
    if (pulse_next == dmdc_pkg::PULSE_FWD) armed_fwd_next = 1'b0;
    if (pulse_next == dmdc_pkg::PULSE_REV) armed_rev_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      armed_fwd <= 1'b0;
      armed_rev <= 1'b0;
      pulse     <= dmdc_pkg::PULSE_NONE;
    end else if (ctrl.adv) begin
      if (step) begin
        state     <= state_next;
        armed_fwd <= armed_fwd_next;
        armed_rev <= armed_rev_next;
        pulse     <= pulse_next;
      end else begin
        pulse     <= dmdc_pkg::PULSE_NONE;
      end
    end
  end

`ifndef SYNTHESIS
  a_fwd_disarms: assert property (@(posedge clk) disable iff (rst)
    (pulse == dmdc_pkg::PULSE_FWD) |-> !armed_fwd)
    else $error("forward pulse left forward arm set");
  a_rev_disarms: assert property (@(posedge clk) disable iff (rst)
    (pulse == dmdc_pkg::PULSE_REV) |-> !armed_rev)
    else $error("reverse pulse left reverse arm set");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (step && state == S_IDLE) |=> (pulse == dmdc_pkg::PULSE_NONE))
    else $error("pulse emitted from idle");
`endif

endmodule

// ===== sv/disc_mark_direction_counter.sv =====
// Path: an accepted request is registered in the average stage (stage 1), then moves
//   on to the result register (trackers, pulse) when that register is empty or taken.
// Throughput: one sample pair per cycle while results are taken; the per-channel
//   average loop (one subtract, one multiply, one add) closes through its register.
// Stalls on the result side hold the pipeline; a new request still enters
//   while the stage-1 slot is free.
// Reset (synchronous, rst high): registers back to defaults, trackers low,
//   sequencer idle, arms clear, first request afterwards only loads averages.
module disc_mark_direction_counter #(
  parameter int SAMPLE_BITS   = dmdc_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = dmdc_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Sample channel
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  logic [SAMPLE_BITS-1:0]           sample_first,
  input  logic [SAMPLE_BITS-1:0]           sample_second,
  // Result channel
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic signed [1:0]                pulse,
  output logic [1:0]                       track_first,
  output logic [1:0]                       track_second,
  // Register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dmdc_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [dmdc_pkg::DATA_BITS-1:0]   pwdata,
  output logic [dmdc_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready
);

  // Configuration registers
  logic [dmdc_pkg::THRESH_BITS-1:0] peak_threshold;
  logic [dmdc_pkg::WEIGHT_BITS-1:0] weight_first;
  logic [dmdc_pkg::WEIGHT_BITS-1:0] weight_second;
  dmdc_pkg::reg_idx_t               reg_idx;
  logic                             reg_write;

  // Pipeline control
  logic            s1_valid;   // a request sits between average and track stages
  logic            s1_prime;   // that request only loaded the averages
  logic            primed;
  logic            accept;
  logic            out_load;
  dmdc_pkg::ctrl_t ctrl;

  dmdc_pkg::trk_t trk_a;
  dmdc_pkg::trk_t trk_b;
  dmdc_pkg::trk_t trk_a_next;
  dmdc_pkg::trk_t trk_b_next;

  // Register port: zero-wait, word index in paddr[3:2]
  assign pready    = 1'b1;
  assign reg_idx   = dmdc_pkg::reg_idx_t'(paddr[3:2]);
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold <= dmdc_pkg::THRESHOLD_RST;
      weight_first   <= dmdc_pkg::WEIGHT_RST;
      weight_second  <= dmdc_pkg::WEIGHT_RST;
    end else if (reg_write) begin
      case (reg_idx)
        dmdc_pkg::REG_THRESHOLD: peak_threshold <= pwdata[dmdc_pkg::THRESH_BITS-1:0];
        dmdc_pkg::REG_WEIGHT_A:  weight_first   <= pwdata[dmdc_pkg::WEIGHT_BITS-1:0];
        dmdc_pkg::REG_WEIGHT_B:  weight_second  <= pwdata[dmdc_pkg::WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dmdc_pkg::REG_THRESHOLD: prdata = dmdc_pkg::DATA_BITS'(peak_threshold);
      dmdc_pkg::REG_WEIGHT_A:  prdata = dmdc_pkg::DATA_BITS'(weight_first);
      dmdc_pkg::REG_WEIGHT_B:  prdata = dmdc_pkg::DATA_BITS'(weight_second);
      default:                 prdata = '0;
    endcase
  end

  // Handshake: the result register reloads when empty or taken; stage 1
  // frees up whenever its request moves on, so accepts run back to back while results move.
  assign out_load     = s1_valid && (!result_valid || result_ready);
  assign sample_ready = !s1_valid || out_load;
  assign accept       = sample_valid && sample_ready;

  assign ctrl.take  = accept;
  assign ctrl.prime = !primed;
  assign ctrl.adv   = out_load;
  assign ctrl.load  = s1_prime;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s1_prime     <= 1'b0;
      primed       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        s1_prime <= !primed;
        primed   <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // One lane per sensor channel: average, mark test, tracker
  dmdc_lane #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lane_a (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .sample     (sample_first),
    .weight     (weight_first),
    .threshold  (peak_threshold),
    .track      (trk_a),
    .track_next (trk_a_next)
  );

  dmdc_lane #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lane_b (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .sample     (sample_second),
    .weight     (weight_second),
    .threshold  (peak_threshold),
    .track      (trk_b),
    .track_next (trk_b_next)
  );

  // Merge: order both channels' edges into direction pulses
  dmdc_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .trk_a (trk_a_next),
    .trk_b (trk_b_next),
    .pulse (pulse)
  );

  assign track_first  = trk_a;
  assign track_second = trk_b;

`ifndef SYNTHESIS
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && result_valid && !result_ready) |-> !sample_ready)
    else $error("request taken while stage 1 is blocked");
  a_load_no_pulse: assert property (@(posedge clk) disable iff (rst)
    (out_load && s1_prime) |=> (pulse == dmdc_pkg::PULSE_NONE))
    else $error("loading request produced a pulse");
  a_primed_sticks: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("primed flag dropped without reset");
`endif

endmodule

// ===== tb/dmdc_checker.sv =====
module dmdc_checker
  import dmdc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  input  logic                         sample_ready,
  input  logic [SAMPLE_BITS_DEF-1:0]   sample_first,
  input  logic [SAMPLE_BITS_DEF-1:0]   sample_second,
  input  logic                         result_valid,
  input  logic                         result_ready,
  input  logic signed [1:0]            pulse,
  input  logic [1:0]                   track_first,
  input  logic [1:0]                   track_second,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_BITS-1:0]         paddr,
  input  logic [DATA_BITS-1:0]         pwdata,
  input  logic [DATA_BITS-1:0]         prdata,
  input  logic                         pready,
  output int                           errors,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam int AW = SB + FB;

  typedef enum logic [3:0] {
    SEQ_IDLE    = 4'd0,
    SEQ_A_FIRST = 4'd1,
    SEQ_A_BOTH  = 4'd2,
    SEQ_MARK    = 4'd3,
    SEQ_B_FIRST = 4'd4,
    SEQ_B_BOTH  = 4'd5,
    SEQ_A_FALL  = 4'd6,
    SEQ_B_FALL  = 4'd7,
    SEQ_B_LAST  = 4'd8,
    SEQ_A_LAST  = 4'd9
  } seq_t;

  typedef struct packed {
    logic signed [1:0] pulse;
    trk_t              tf;
    trk_t              ts;
  } disc_result_t;

  logic [THRESH_BITS-1:0] thresh;
  logic [WEIGHT_BITS-1:0] weight_a;
  logic [WEIGHT_BITS-1:0] weight_b;
  logic [AW-1:0]          avg_a;
  logic [AW-1:0]          avg_b;
  trk_t                   trk_a;
  trk_t                   trk_b;
  seq_t                   seq;
  logic                   armed_fwd;
  logic                   armed_rev;
  logic                   primed;
  disc_result_t           disc_results[$];
  int                     fail_count = 0;

  // Floored weighted step toward the new sample
  function automatic logic [AW-1:0] smooth(logic [AW-1:0] avg, logic [SB-1:0] x,
                                           logic [WEIGHT_BITS-1:0] w);
    longint gap;
    longint step;
    gap = longint'({x, {FB{1'b0}}}) - longint'(avg);
    step = (gap * longint'(w)) >>> WEIGHT_BITS;
    return AW'(longint'(avg) + step);
  endfunction

  function automatic trk_t next_track(trk_t t, logic [AW-1:0] avg, logic [SB-1:0] x,
                                      logic [THRESH_BITS-1:0] th);
    if (longint'(avg) >= ((longint'(x) + longint'(th)) << FB)) begin
      if (t == TRK_LOW) return TRK_RISE;
      if (t == TRK_RISE) return TRK_HIGH;
      return t;
    end
    if (t == TRK_HIGH) return TRK_FALL;
    return TRK_LOW;
  endfunction

  function automatic void check_field(string what, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  task automatic step_disc(input logic [SB-1:0] xa, input logic [SB-1:0] xb,
                           output disc_result_t r);
    logic signed [1:0] p;
    p = PULSE_NONE;
    if (!primed) begin
      // first pair only loads the averages
      avg_a = {xa, {FB{1'b0}}};
      avg_b = {xb, {FB{1'b0}}};
      primed = 1'b1;
    end else begin
      avg_a = smooth(avg_a, xa, weight_a);
      trk_a = next_track(trk_a, avg_a, xa, thresh);
      avg_b = smooth(avg_b, xb, weight_b);
      trk_b = next_track(trk_b, avg_b, xb, thresh);
      case (seq)
        SEQ_IDLE: begin
          armed_fwd = 1'b1;
          armed_rev = 1'b1;
          if (trk_a == TRK_RISE) seq = SEQ_A_FIRST;
          if (trk_b == TRK_RISE) seq = SEQ_B_FIRST;
        end
        SEQ_A_FIRST: if (trk_b == TRK_RISE) seq = SEQ_A_BOTH;
        SEQ_A_BOTH: begin
          if (armed_fwd) p = PULSE_FWD;
          seq = SEQ_MARK;
        end
        SEQ_MARK: begin
          if (trk_b == TRK_FALL) seq = SEQ_B_FALL;
          if (trk_a == TRK_FALL) seq = SEQ_A_FALL;
        end
        SEQ_B_FALL: begin
          if (trk_b inside {TRK_HIGH, TRK_RISE}) seq = SEQ_MARK;
          if (trk_a == TRK_FALL) seq = SEQ_A_LAST;
        end
        SEQ_A_LAST: begin
          if (armed_rev) p = PULSE_REV;
          seq = SEQ_IDLE;
        end
        SEQ_B_FIRST: if (trk_a == TRK_RISE) seq = SEQ_B_BOTH;
        SEQ_B_BOTH: begin
          if (armed_rev) p = PULSE_REV;
          seq = SEQ_MARK;
        end
        SEQ_A_FALL: begin
          if (trk_a inside {TRK_HIGH, TRK_RISE}) seq = SEQ_MARK;
          if (trk_b == TRK_FALL) seq = SEQ_B_LAST;
        end
        SEQ_B_LAST: begin
          if (armed_fwd) p = PULSE_FWD;
          seq = SEQ_IDLE;
        end
        default: seq = SEQ_IDLE;
      endcase
      if (p == PULSE_FWD) armed_fwd = 1'b0;
      if (p == PULSE_REV) armed_rev = 1'b0;
    end
    r.pulse = p;
    r.tf = trk_a;
    r.ts = trk_b;
  endtask

  always @(posedge clk) begin
    disc_result_t want;
    reg_idx_t     idx;
    longint       reg_want;
    if (rst) begin
      thresh = THRESHOLD_RST;
      weight_a = WEIGHT_RST;
      weight_b = WEIGHT_RST;
      avg_a = '0;
      avg_b = '0;
      trk_a = TRK_LOW;
      trk_b = TRK_LOW;
      seq = SEQ_IDLE;
      armed_fwd = 1'b0;
      armed_rev = 1'b0;
      primed = 1'b0;
      disc_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (disc_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual pulse %0d tracks %0d %0d",
                   $time, pulse, track_first, track_second);
          fail_count++;
        end else begin
          want = disc_results.pop_front();
          check_field("pulse", want.pulse, pulse);
          check_field("track_first", want.tf, track_first);
          check_field("track_second", want.ts, track_second);
        end
      end
      if (psel && penable && pready) begin
        idx = reg_idx_t'(paddr[3:2]);
        if (pwrite) begin
          case (idx)
            REG_THRESHOLD: thresh = pwdata[THRESH_BITS-1:0];
            REG_WEIGHT_A:  weight_a = pwdata[WEIGHT_BITS-1:0];
            REG_WEIGHT_B:  weight_b = pwdata[WEIGHT_BITS-1:0];
            default: ;
          endcase
        end else if (idx != REG_NONE) begin
          case (idx)
            REG_THRESHOLD: reg_want = thresh;
            REG_WEIGHT_A:  reg_want = weight_a;
            default:       reg_want = weight_b;
          endcase
          check_field("prdata", reg_want, prdata);
        end
      end
      if (sample_valid && sample_ready) begin
        step_disc(sample_first, sample_second, want);
        disc_results.push_back(want);
      end
    end
    errors <= fail_count;
    pending <= disc_results.size();
  end

endmodule

// ===== tb/disc_mark_direction_counter_test.sv =====
module disc_mark_direction_counter_test;
  import dmdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int SMAX        = (1 << SB) - 1;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 155;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    sample_valid = 1'b0;
  logic                    sample_ready;
  logic [SB-1:0]           sample_first = '0;
  logic [SB-1:0]           sample_second = '0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  logic signed [1:0]       pulse;
  logic [1:0]              track_first;
  logic [1:0]              track_second;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_BITS-1:0]    paddr = '0;
  logic [DATA_BITS-1:0]    pwdata = '0;
  logic [DATA_BITS-1:0]    prdata;
  logic                    pready;

  int   errors;
  int   pending;
  int   quiet_cycles = 0;
  // random idling on both sides; cleared for one whole phase
  logic idle_en = 1'b1;
  // bump to make the receiver hold off for a long stretch
  int   hold_ask = 0;
  // sensor baselines of the current phase
  int   level_a;
  int   level_b;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  disc_mark_direction_counter u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_first (sample_first),
    .sample_second(sample_second),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pulse        (pulse),
    .track_first  (track_first),
    .track_second (track_second),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  dmdc_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_first (sample_first),
    .sample_second(sample_second),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pulse        (pulse),
    .track_first  (track_first),
    .track_second (track_second),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .errors       (errors),
    .pending      (pending)
  );

  // Receiver: drop ready now and then; on a hold-off request keep it low for
  // a long stretch so the pipeline fills and backs up into the sample side.
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        result_ready <= !(idle_en && $urandom_range(99) < 7);
      end
    end
  end

  // Watchdog: end the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [SB-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > SMAX) return SB'(SMAX);
    return v[SB-1:0];
  endfunction

  // Offer one sample pair and hold it until the block takes the request.
  // Valid stays high into the next request unless a gap is inserted.
  task automatic put_pair(input logic [SB-1:0] a, input logic [SB-1:0] b);
    if (idle_en && $urandom_range(99) < 7) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_first <= a;
    sample_second <= b;
    do @(posedge clk); while (!sample_ready);
  endtask

  // Drop valid and wait until every result has come back.
  task automatic settle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [DATA_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Read back the three registers; the checker compares prdata.
  task automatic read_regs();
    reg_idx_t idx;
    idx = REG_THRESHOLD;
    repeat (3) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      idx = idx.next();
    end
  endtask

  // One mark crossing the two sensors with a random lead, overlap and
  // direction; with one_sided set only one sensor sees the mark.
  task automatic mark_passage(input bit one_sided, output int count);
    int  drop_a, drop_b, len_a, len_b, lag, lead, start_a, start_b, total, i;
    bit  in_a, in_b;
    drop_a = int'($urandom_range(level_a, level_a / 3));
    drop_b = int'($urandom_range(level_b, level_b / 3));
    len_a = int'($urandom_range(6, 1));
    len_b = int'($urandom_range(6, 1));
    lag = int'($urandom_range(3, 0));
    lead = int'($urandom_range(3, 1));
    if ($urandom_range(1)) begin
      start_a = lead;
      start_b = lead + lag;
    end else begin
      start_b = lead;
      start_a = lead + lag;
    end
    if (one_sided) begin
      if ($urandom_range(1)) drop_a = 0;
      else drop_b = 0;
    end
    total = ((start_a + len_a > start_b + len_b) ? start_a + len_a : start_b + len_b)
            + int'($urandom_range(4, 2));
    for (i = 0; i < total; i++) begin
      in_a = (i >= start_a) && (i < start_a + len_a);
      in_b = (i >= start_b) && (i < start_b + len_b);
      put_pair(clip(level_a + int'($urandom_range(6)) - 3 - (in_a ? drop_a : 0)),
               clip(level_b + int'($urandom_range(6)) - 3 - (in_b ? drop_b : 0)));
    end
    count = total;
  endtask

  // Mostly clean passages, some one-sided ones, some raw noise.
  task automatic run_phase(input int n_items);
    int sent, kind, burst;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(19) == 0) begin
        level_a = int'($urandom_range(SMAX, 150));
        level_b = int'($urandom_range(SMAX, 150));
      end
      kind = int'($urandom_range(99));
      if (kind < 75) begin
        mark_passage(kind >= 62, burst);
      end else begin
        burst = int'($urandom_range(10, 1));
        repeat (burst) put_pair(SB'($urandom_range(SMAX)), SB'($urandom_range(SMAX)));
      end
      sent += burst;
    end
  endtask

  initial begin
    int ph;
    int thr, wa, wb;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of the registers
    read_regs();

    // Directed: the loading pair, a forward then a reverse crossing at full
    // swing, then the corners of the sample range.
    put_pair(SB'(SMAX), SB'(SMAX));
    put_pair(SB'(SMAX), SB'(SMAX));
    put_pair('0, SB'(SMAX));
    put_pair('0, '0);
    put_pair('0, '0);
    put_pair(SB'(SMAX), '0);
    put_pair(SB'(SMAX), '0);
    put_pair(SB'(SMAX), SB'(SMAX));
    put_pair(SB'(SMAX), SB'(SMAX));
    put_pair(SB'(SMAX), SB'(SMAX));
    put_pair(SB'(SMAX), '0);
    put_pair('0, '0);
    put_pair('0, '0);
    put_pair('0, SB'(SMAX));
    put_pair('0, SB'(SMAX));
    put_pair(SB'(SMAX), SB'(SMAX));
    put_pair(SB'(SMAX), SB'(SMAX));
    put_pair('0, '0);
    put_pair(SB'(SMAX), SB'(SMAX));
    put_pair(SB'(512), SB'(511));
    put_pair(SB'(SMAX), '0);
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      // Pick the phase setting; the first three cover the extremes,
      // including a weight of zero that freezes an average.
      case (ph)
        0: begin
          thr = 0;
          wa = 65535;
          wb = 0;
        end
        1: begin
          thr = SMAX;
          wa = 0;
          wb = 65535;
        end
        2: begin
          thr = 35;
          wa = 1;
          wb = 1;
        end
        default: begin
          thr = ($urandom_range(3) == 0) ? int'($urandom_range(SMAX)) :
                                          int'($urandom_range(120, 5));
          wa = ($urandom_range(3) == 0) ? int'($urandom_range(65535, 1)) :
                                         int'($urandom_range(4000, 1));
          wb = ($urandom_range(3) == 0) ? int'($urandom_range(65535, 1)) :
                                         int'($urandom_range(4000, 1));
        end
      endcase
      // upper data bits are junk the registers must drop
      reg_write(REG_THRESHOLD, ($urandom() << THRESH_BITS) | thr);
      reg_write(REG_WEIGHT_A, ($urandom() << WEIGHT_BITS) | wa);
      reg_write(REG_WEIGHT_B, ($urandom() << WEIGHT_BITS) | wb);
      // a write to the unused slot must change nothing
      if (ph < 2) reg_write(REG_NONE, $urandom());
      read_regs();

      level_a = int'($urandom_range(SMAX, 150));
      level_b = int'($urandom_range(SMAX, 150));
      idle_en <= (ph != 3);
      if (ph == 5) hold_ask <= hold_ask + 1;

      run_phase(PHASE_ITEMS / 2);
      // pause the sender once mid-phase until the pipeline is empty
      if (ph == 6) settle();
      run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
      settle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dmdc_pkg.sv
sv/dmdc_lane.sv
sv/dmdc_seq.sv
sv/disc_mark_direction_counter.sv
tb/dmdc_checker.sv
tb/disc_mark_direction_counter_test.sv
